// ===== design/sac_pkg.sv =====
// shared types and codes for the suffix automaton common substring block
`default_nettype none
package sac_pkg;

  // field widths fixed by the interface
  localparam int OP_W   = 2;
  localparam int SYM_W  = 5;
  localparam int STS_W  = 2;
  localparam int ANS_W  = 11;
  localparam int ANS_MAX = 2047;

  // opcodes
  localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
  localparam logic [OP_W-1:0] OP_MATCH  = 2'd1;
  localparam logic [OP_W-1:0] OP_END    = 2'd2;
  localparam logic [OP_W-1:0] OP_REPORT = 2'd3;

  // status codes
  localparam logic [STS_W-1:0] STS_OK   = 2'd0;
  localparam logic [STS_W-1:0] STS_FULL = 2'd1;
  localparam logic [STS_W-1:0] STS_LATE = 2'd2;

  // sequencer states
  typedef enum logic [5:0] {
    S_CLEAR,
    S_IDLE,
    S_AP_RD,
    S_AP_CHK,
    S_AP_LNK,
    S_AP_P,
    S_AP_Q,
    S_AP_CL,
    S_AP_CUR,
    S_CP,
    S_RD_RD,
    S_RD_CHK,
    S_RD_LNK,
    S_SO_CLR,
    S_SO_CNT_RD,
    S_SO_CNT_LEN,
    S_SO_CNT_WR,
    S_SO_PRE_RD,
    S_SO_PRE_WR,
    S_SO_ORD_RD,
    S_SO_ORD_LEN,
    S_SO_ORD_WR,
    S_MA_RD,
    S_MA_CHK,
    S_MA_LNK_RD,
    S_MA_LNK,
    S_MA_T_RD,
    S_MA_T,
    S_MA_LEN,
    S_MA_UPD_RD,
    S_MA_UPD,
    S_EQ_ORD,
    S_EQ_U,
    S_EQ_UR,
    S_EQ_F,
    S_EQ_W,
    S_RP_RD,
    S_RP_CMP,
    S_DONE
  } sac_state_t;

endpackage
`default_nettype wire

// ===== design/sac_ram.sv =====
// generic single write port ram with registered read
`default_nettype none
module sac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== design/suffix_automaton_common_substring.sv =====
// suffix automaton longest common substring engine, top level
//
//   channel | direction | fields           | handshake
//   in      | input     | opcode, symbol   | in_valid / in_stall
//   out     | output    | status, answer   | out_valid / out_stall
//
// one item at a time, one result beat per item; a new item is taken only in idle
// with the result register empty. append: walks suffix links, and when a clone is made,
// copies the transition row of q into it and redirects links to it. match letter: follows
// a transition or walks suffix links. the first match or end item first runs a counting
// sort of the nodes by length. end of query: visits each node. report: scans node records.
// after reset a clearing pass holds in_stall.
`default_nettype none
module suffix_automaton_common_substring #(
  parameter int MAX_REF_LEN   = 1024,
  parameter int ALPHABET_SIZE = 26
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [sac_pkg::OP_W-1:0]  in_opcode,
  input  wire logic [sac_pkg::SYM_W-1:0] in_symbol,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [sac_pkg::STS_W-1:0]      out_status,
  output logic [sac_pkg::ANS_W-1:0]      out_answer
);

  localparam int NC   = 2 * MAX_REF_LEN;
  localparam int NW   = $clog2(NC);
  localparam int CW   = NW + 1;
  localparam int LW   = $clog2(MAX_REF_LEN + 1);
  localparam int TD   = NC * ALPHABET_SIZE;
  localparam int TW   = $clog2(TD);
  localparam int CTW  = $clog2(TD + 1);
  localparam int NRW  = NW + 3 * LW;

  // state and registers
  sac_pkg::sac_state_t state_r, state_nxt;
  logic [sac_pkg::OP_W-1:0]  op_r, op_nxt;
  logic [sac_pkg::SYM_W-1:0] sym_r, sym_nxt;
  logic [sac_pkg::STS_W-1:0] status_r, status_nxt;
  logic [NW-1:0]  p_r, p_nxt;
  logic [NW-1:0]  cur_r, cur_nxt;
  logic [NW-1:0]  q_r, q_nxt;
  logic [NW-1:0]  cl_r, cl_nxt;
  logic [NW-1:0]  qlink_r, qlink_nxt;
  logic [LW-1:0]  lenp_r, lenp_nxt;
  logic [LW-1:0]  len_r, len_nxt;
  logic [CTW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0]  acc_r, acc_nxt;
  logic [NW-1:0]  u_r, u_nxt;
  logic [NRW-1:0] urec_r, urec_nxt;
  logic [CW-1:0]  nc_r, nc_nxt;
  logic [NW-1:0]  last_r, last_nxt;
  logic [LW-1:0]  ref_len_r, ref_len_nxt;
  logic [NW-1:0]  mnode_r, mnode_nxt;
  logic [LW-1:0]  mlen_r, mlen_nxt;
  logic           started_r, started_nxt;
  logic [LW-1:0]  best_r, best_nxt;
  logic           out_valid_r;
  logic [sac_pkg::STS_W-1:0] out_status_r;
  logic [sac_pkg::ANS_W-1:0] out_answer_r;

  // memory ports
  logic           tr_we;
  logic [TW-1:0]  tr_waddr, tr_raddr;
  logic [NW-1:0]  tr_wdata, tr_rd;
  logic           nd_we;
  logic [NW-1:0]  nd_waddr, nd_raddr;
  logic [NRW-1:0] nd_wdata, nd_rd;
  logic           bk_we;
  logic [LW-1:0]  bk_waddr, bk_raddr;
  logic [CW-1:0]  bk_wdata, bk_rd;
  logic           od_we;
  logic [NW-1:0]  od_waddr, od_raddr;
  logic [NW-1:0]  od_wdata, od_rd;

  // derived values
  logic          in_fire;
  logic          in_sym_ok, sym_ok, ref_full;
  logic [NW-1:0] rd_link, u_link;
  logic [LW-1:0] rd_len, rd_bq, rd_ba, u_len, u_bq, u_ba;
  logic          tr_zero, p_zero;
  logic [CW-1:0] bk_dec, bk_sum;
  logic [31:0]   best32;

  function automatic logic [TW-1:0] taddr(input logic [NW-1:0] n, input logic [TW-1:0] s);
    return TW'(n) * TW'(ALPHABET_SIZE) + s;
  endfunction

  function automatic logic [NRW-1:0] rec(input logic [NW-1:0] l, input logic [LW-1:0] n,
                                         input logic [LW-1:0] b, input logic [LW-1:0] a);
    return {l, n, b, a};
  endfunction

  // transitions, node records, length buckets and length order
  sac_ram #(.WIDTH(NW), .DEPTH(TD)) u_trans (
    .clk(clk), .we(tr_we), .waddr(tr_waddr), .wdata(tr_wdata),
    .raddr(tr_raddr), .rdata(tr_rd)
  );

  sac_ram #(.WIDTH(NRW), .DEPTH(NC)) u_node (
    .clk(clk), .we(nd_we), .waddr(nd_waddr), .wdata(nd_wdata),
    .raddr(nd_raddr), .rdata(nd_rd)
  );

  sac_ram #(.WIDTH(CW), .DEPTH(MAX_REF_LEN + 1)) u_bucket (
    .clk(clk), .we(bk_we), .waddr(bk_waddr), .wdata(bk_wdata),
    .raddr(bk_raddr), .rdata(bk_rd)
  );

  sac_ram #(.WIDTH(NW), .DEPTH(NC)) u_order (
    .clk(clk), .we(od_we), .waddr(od_waddr), .wdata(od_wdata),
    .raddr(od_raddr), .rdata(od_rd)
  );

  // field split and flags
  assign rd_link  = nd_rd[NRW-1 -: NW];
  assign rd_len   = nd_rd[3*LW-1 -: LW];
  assign rd_bq    = nd_rd[2*LW-1 -: LW];
  assign rd_ba    = nd_rd[LW-1:0];
  assign u_link   = urec_r[NRW-1 -: NW];
  assign u_len    = urec_r[3*LW-1 -: LW];
  assign u_bq     = urec_r[2*LW-1 -: LW];
  assign u_ba     = urec_r[LW-1:0];
  assign in_sym_ok = 32'(in_symbol) < 32'(ALPHABET_SIZE);
  assign sym_ok    = 32'(sym_r) < 32'(ALPHABET_SIZE);
  assign ref_full  = ref_len_r >= LW'(MAX_REF_LEN);
  assign tr_zero   = tr_rd == '0;
  assign p_zero    = p_r == '0;
  assign bk_dec    = bk_rd - CW'(1);
  assign bk_sum    = acc_r + bk_rd;
  assign best32    = 32'(best_r);

  // handshake
  assign in_stall   = (state_r != sac_pkg::S_IDLE) || out_valid_r;
  assign in_fire    = in_valid && !in_stall;
  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_answer = out_answer_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sac_pkg::S_CLEAR: begin
        if (cnt_r == CTW'(TD - 1)) state_nxt = sac_pkg::S_IDLE;
      end
      sac_pkg::S_IDLE: begin
        if (in_fire) begin
          case (in_opcode)
            sac_pkg::OP_APPEND: begin
              if (started_r || !in_sym_ok || ref_full) state_nxt = sac_pkg::S_DONE;
              else state_nxt = sac_pkg::S_AP_RD;
            end
            sac_pkg::OP_MATCH: begin
              state_nxt = started_r ? sac_pkg::S_MA_RD : sac_pkg::S_SO_CLR;
            end
            sac_pkg::OP_END: begin
              state_nxt = started_r ? sac_pkg::S_EQ_ORD : sac_pkg::S_SO_CLR;
            end
            default: state_nxt = sac_pkg::S_RP_RD;
          endcase
        end
      end
      sac_pkg::S_AP_RD:  state_nxt = sac_pkg::S_AP_CHK;
      sac_pkg::S_AP_CHK: begin
        if (!tr_zero) state_nxt = sac_pkg::S_AP_P;
        else if (p_zero) state_nxt = sac_pkg::S_DONE;
        else state_nxt = sac_pkg::S_AP_LNK;
      end
      sac_pkg::S_AP_LNK: state_nxt = sac_pkg::S_AP_RD;
      sac_pkg::S_AP_P:   state_nxt = sac_pkg::S_AP_Q;
      sac_pkg::S_AP_Q: begin
        if (lenp_r + LW'(1) == rd_len) state_nxt = sac_pkg::S_DONE;
        else state_nxt = sac_pkg::S_AP_CL;
      end
      sac_pkg::S_AP_CL:  state_nxt = sac_pkg::S_AP_CUR;
      sac_pkg::S_AP_CUR: state_nxt = sac_pkg::S_CP;
      sac_pkg::S_CP: begin
        if (cnt_r == CTW'(ALPHABET_SIZE)) state_nxt = sac_pkg::S_RD_RD;
      end
      sac_pkg::S_RD_RD:  state_nxt = sac_pkg::S_RD_CHK;
      sac_pkg::S_RD_CHK: begin
        if (tr_rd == q_r && !p_zero) state_nxt = sac_pkg::S_RD_LNK;
        else state_nxt = sac_pkg::S_DONE;
      end
      sac_pkg::S_RD_LNK: state_nxt = sac_pkg::S_RD_RD;
      sac_pkg::S_SO_CLR: begin
        if (cnt_r == CTW'(MAX_REF_LEN)) state_nxt = sac_pkg::S_SO_CNT_RD;
      end
      sac_pkg::S_SO_CNT_RD:  state_nxt = sac_pkg::S_SO_CNT_LEN;
      sac_pkg::S_SO_CNT_LEN: state_nxt = sac_pkg::S_SO_CNT_WR;
      sac_pkg::S_SO_CNT_WR: begin
        if (cnt_r + CTW'(1) == CTW'(nc_r)) state_nxt = sac_pkg::S_SO_PRE_RD;
        else state_nxt = sac_pkg::S_SO_CNT_RD;
      end
      sac_pkg::S_SO_PRE_RD: state_nxt = sac_pkg::S_SO_PRE_WR;
      sac_pkg::S_SO_PRE_WR: begin
        if (cnt_r == CTW'(MAX_REF_LEN)) state_nxt = sac_pkg::S_SO_ORD_RD;
        else state_nxt = sac_pkg::S_SO_PRE_RD;
      end
      sac_pkg::S_SO_ORD_RD:  state_nxt = sac_pkg::S_SO_ORD_LEN;
      sac_pkg::S_SO_ORD_LEN: state_nxt = sac_pkg::S_SO_ORD_WR;
      sac_pkg::S_SO_ORD_WR: begin
        if (cnt_r != CTW'(1)) state_nxt = sac_pkg::S_SO_ORD_RD;
        else if (op_r == sac_pkg::OP_MATCH) state_nxt = sac_pkg::S_MA_RD;
        else state_nxt = sac_pkg::S_EQ_ORD;
      end
      sac_pkg::S_MA_RD: begin
        state_nxt = sym_ok ? sac_pkg::S_MA_CHK : sac_pkg::S_MA_UPD_RD;
      end
      sac_pkg::S_MA_CHK: begin
        if (!tr_zero || mnode_r == '0) state_nxt = sac_pkg::S_MA_UPD_RD;
        else state_nxt = sac_pkg::S_MA_LNK_RD;
      end
      sac_pkg::S_MA_LNK_RD: state_nxt = sac_pkg::S_MA_LNK;
      sac_pkg::S_MA_LNK:    state_nxt = sac_pkg::S_MA_T_RD;
      sac_pkg::S_MA_T_RD:   state_nxt = sac_pkg::S_MA_T;
      sac_pkg::S_MA_T: begin
        if (!tr_zero) state_nxt = sac_pkg::S_MA_LEN;
        else if (p_zero) state_nxt = sac_pkg::S_MA_UPD_RD;
        else state_nxt = sac_pkg::S_MA_LNK_RD;
      end
      sac_pkg::S_MA_LEN:    state_nxt = sac_pkg::S_MA_UPD_RD;
      sac_pkg::S_MA_UPD_RD: state_nxt = sac_pkg::S_MA_UPD;
      sac_pkg::S_MA_UPD:    state_nxt = sac_pkg::S_DONE;
      sac_pkg::S_EQ_ORD:    state_nxt = sac_pkg::S_EQ_U;
      sac_pkg::S_EQ_U:      state_nxt = sac_pkg::S_EQ_UR;
      sac_pkg::S_EQ_UR: begin
        state_nxt = (u_r != '0) ? sac_pkg::S_EQ_F : sac_pkg::S_EQ_W;
      end
      sac_pkg::S_EQ_F: state_nxt = sac_pkg::S_EQ_W;
      sac_pkg::S_EQ_W: begin
        state_nxt = (cnt_r == CTW'(1)) ? sac_pkg::S_DONE : sac_pkg::S_EQ_ORD;
      end
      sac_pkg::S_RP_RD: state_nxt = sac_pkg::S_RP_CMP;
      sac_pkg::S_RP_CMP: begin
        if (cnt_r + CTW'(1) == CTW'(nc_r)) state_nxt = sac_pkg::S_DONE;
        else state_nxt = sac_pkg::S_RP_RD;
      end
      sac_pkg::S_DONE: state_nxt = sac_pkg::S_IDLE;
      default: state_nxt = sac_pkg::S_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    op_nxt      = op_r;
    sym_nxt     = sym_r;
    status_nxt  = status_r;
    p_nxt       = p_r;
    cur_nxt     = cur_r;
    q_nxt       = q_r;
    cl_nxt      = cl_r;
    qlink_nxt   = qlink_r;
    lenp_nxt    = lenp_r;
    len_nxt     = len_r;
    cnt_nxt     = cnt_r;
    acc_nxt     = acc_r;
    u_nxt       = u_r;
    urec_nxt    = urec_r;
    nc_nxt      = nc_r;
    last_nxt    = last_r;
    ref_len_nxt = ref_len_r;
    mnode_nxt   = mnode_r;
    mlen_nxt    = mlen_r;
    started_nxt = started_r;
    best_nxt    = best_r;
    tr_we = 1'b0; tr_waddr = '0; tr_wdata = '0; tr_raddr = '0;
    nd_we = 1'b0; nd_waddr = '0; nd_wdata = '0; nd_raddr = '0;
    bk_we = 1'b0; bk_waddr = '0; bk_wdata = '0; bk_raddr = '0;
    od_we = 1'b0; od_waddr = '0; od_wdata = '0; od_raddr = '0;
    case (state_r)
      // sweep transitions and node records to zero
      sac_pkg::S_CLEAR: begin
        tr_we    = 1'b1;
        tr_waddr = cnt_r[TW-1:0];
        if (cnt_r < CTW'(NC)) begin
          nd_we    = 1'b1;
          nd_waddr = cnt_r[NW-1:0];
        end
        cnt_nxt = (cnt_r == CTW'(TD - 1)) ? '0 : cnt_r + CTW'(1);
      end
      // take an item
      sac_pkg::S_IDLE: begin
        if (in_fire) begin
          op_nxt     = in_opcode;
          sym_nxt    = in_symbol;
          status_nxt = sac_pkg::STS_OK;
          best_nxt   = '0;
          cnt_nxt    = '0;
          case (in_opcode)
            sac_pkg::OP_APPEND: begin
              if (started_r) begin
                status_nxt = sac_pkg::STS_LATE;
              end else if (!in_sym_ok || ref_full) begin
                status_nxt = sac_pkg::STS_FULL;
              end else begin
                cur_nxt     = nc_r[NW-1:0];
                nc_nxt      = nc_r + CW'(1);
                ref_len_nxt = ref_len_r + LW'(1);
                p_nxt       = last_r;
                last_nxt    = nc_r[NW-1:0];
                nd_we       = 1'b1;
                nd_waddr    = nc_r[NW-1:0];
                nd_wdata    = rec('0, ref_len_r + LW'(1), '0, ref_len_r + LW'(1));
              end
            end
            sac_pkg::OP_MATCH, sac_pkg::OP_END: begin
              started_nxt = 1'b1;
              if (started_r) cnt_nxt = CTW'(nc_r);
            end
            default: ;
          endcase
        end
      end
      // first suffix link walk of an append
      sac_pkg::S_AP_RD: tr_raddr = taddr(p_r, TW'(sym_r));
      sac_pkg::S_AP_CHK: begin
        if (tr_zero) begin
          tr_we    = 1'b1;
          tr_waddr = taddr(p_r, TW'(sym_r));
          tr_wdata = cur_r;
        end else begin
          q_nxt = tr_rd;
        end
        nd_raddr = p_r;
      end
      sac_pkg::S_AP_LNK: p_nxt = rd_link;
      sac_pkg::S_AP_P: begin
        lenp_nxt = rd_len;
        nd_raddr = q_r;
      end
      sac_pkg::S_AP_Q: begin
        nd_we = 1'b1;
        if (lenp_r + LW'(1) == rd_len) begin
          nd_waddr = cur_r;
          nd_wdata = rec(q_r, ref_len_r, '0, ref_len_r);
        end else begin
          cl_nxt    = nc_r[NW-1:0];
          nc_nxt    = nc_r + CW'(1);
          qlink_nxt = rd_link;
          nd_waddr  = q_r;
          nd_wdata  = rec(nc_r[NW-1:0], rd_len, rd_bq, rd_ba);
        end
      end
      sac_pkg::S_AP_CL: begin
        nd_we    = 1'b1;
        nd_waddr = cl_r;
        nd_wdata = rec(qlink_r, lenp_r + LW'(1), '0, lenp_r + LW'(1));
      end
      sac_pkg::S_AP_CUR: begin
        nd_we    = 1'b1;
        nd_waddr = cur_r;
        nd_wdata = rec(cl_r, ref_len_r, '0, ref_len_r);
        cnt_nxt  = '0;
      end
      // copy the transition row of q into the clone
      sac_pkg::S_CP: begin
        if (cnt_r < CTW'(ALPHABET_SIZE)) tr_raddr = taddr(q_r, TW'(cnt_r));
        if (cnt_r != '0) begin
          tr_we    = 1'b1;
          tr_waddr = taddr(cl_r, TW'(cnt_r - CTW'(1)));
          tr_wdata = tr_rd;
        end
        cnt_nxt = cnt_r + CTW'(1);
      end
      // redirect edges from q to the clone
      sac_pkg::S_RD_RD: tr_raddr = taddr(p_r, TW'(sym_r));
      sac_pkg::S_RD_CHK: begin
        if (tr_rd == q_r) begin
          tr_we    = 1'b1;
          tr_waddr = taddr(p_r, TW'(sym_r));
          tr_wdata = cl_r;
        end
        nd_raddr = p_r;
      end
      sac_pkg::S_RD_LNK: p_nxt = rd_link;
      // counting sort: clear buckets
      sac_pkg::S_SO_CLR: begin
        bk_we    = 1'b1;
        bk_waddr = cnt_r[LW-1:0];
        cnt_nxt  = (cnt_r == CTW'(MAX_REF_LEN)) ? '0 : cnt_r + CTW'(1);
      end
      // counting sort: histogram
      sac_pkg::S_SO_CNT_RD: nd_raddr = cnt_r[NW-1:0];
      sac_pkg::S_SO_CNT_LEN: begin
        len_nxt  = rd_len;
        bk_raddr = rd_len;
      end
      sac_pkg::S_SO_CNT_WR: begin
        bk_we    = 1'b1;
        bk_waddr = len_r;
        bk_wdata = bk_rd + CW'(1);
        acc_nxt  = '0;
        cnt_nxt  = (cnt_r + CTW'(1) == CTW'(nc_r)) ? '0 : cnt_r + CTW'(1);
      end
      // counting sort: prefix sums
      sac_pkg::S_SO_PRE_RD: bk_raddr = cnt_r[LW-1:0];
      sac_pkg::S_SO_PRE_WR: begin
        bk_we    = 1'b1;
        bk_waddr = cnt_r[LW-1:0];
        bk_wdata = bk_sum;
        acc_nxt  = bk_sum;
        cnt_nxt  = (cnt_r == CTW'(MAX_REF_LEN)) ? CTW'(nc_r) : cnt_r + CTW'(1);
      end
      // counting sort: place nodes
      sac_pkg::S_SO_ORD_RD: nd_raddr = NW'(cnt_r - CTW'(1));
      sac_pkg::S_SO_ORD_LEN: begin
        len_nxt  = rd_len;
        bk_raddr = rd_len;
      end
      sac_pkg::S_SO_ORD_WR: begin
        bk_we    = 1'b1;
        bk_waddr = len_r;
        bk_wdata = bk_dec;
        od_we    = 1'b1;
        od_waddr = bk_dec[NW-1:0];
        od_wdata = NW'(cnt_r - CTW'(1));
        cnt_nxt  = (cnt_r == CTW'(1)) ? CTW'(nc_r) : cnt_r - CTW'(1);
      end
      // match a query letter
      sac_pkg::S_MA_RD: begin
        if (sym_ok) begin
          tr_raddr = taddr(mnode_r, TW'(sym_r));
        end else begin
          mnode_nxt = '0;
          mlen_nxt  = '0;
        end
      end
      sac_pkg::S_MA_CHK: begin
        if (!tr_zero) begin
          mnode_nxt = tr_rd;
          mlen_nxt  = mlen_r + LW'(1);
        end else if (mnode_r == '0) begin
          mlen_nxt = '0;
        end else begin
          p_nxt = mnode_r;
        end
      end
      sac_pkg::S_MA_LNK_RD: nd_raddr = p_r;
      sac_pkg::S_MA_LNK:    p_nxt = rd_link;
      sac_pkg::S_MA_T_RD:   tr_raddr = taddr(p_r, TW'(sym_r));
      sac_pkg::S_MA_T: begin
        if (!tr_zero) begin
          mnode_nxt = tr_rd;
          nd_raddr  = p_r;
        end else if (p_zero) begin
          mnode_nxt = '0;
          mlen_nxt  = '0;
        end
      end
      sac_pkg::S_MA_LEN:    mlen_nxt = rd_len + LW'(1);
      sac_pkg::S_MA_UPD_RD: nd_raddr = mnode_r;
      sac_pkg::S_MA_UPD: begin
        if (rd_bq < mlen_r) begin
          nd_we    = 1'b1;
          nd_waddr = mnode_r;
          nd_wdata = rec(rd_link, rd_len, mlen_r, rd_ba);
        end
      end
      // end of query: propagate up suffix links in descending length
      sac_pkg::S_EQ_ORD: od_raddr = NW'(cnt_r - CTW'(1));
      sac_pkg::S_EQ_U: begin
        u_nxt    = od_rd;
        nd_raddr = od_rd;
      end
      sac_pkg::S_EQ_UR: begin
        urec_nxt = nd_rd;
        nd_raddr = rd_link;
      end
      sac_pkg::S_EQ_F: begin
        if (rd_bq < u_bq) begin
          nd_we    = 1'b1;
          nd_waddr = u_link;
          nd_wdata = rec(rd_link, rd_len, u_bq, rd_ba);
        end
      end
      sac_pkg::S_EQ_W: begin
        nd_we    = 1'b1;
        nd_waddr = u_r;
        nd_wdata = rec(u_link, u_len, '0, (u_ba > u_bq) ? u_bq : u_ba);
        cnt_nxt  = cnt_r - CTW'(1);
        if (cnt_r == CTW'(1)) begin
          mnode_nxt = '0;
          mlen_nxt  = '0;
        end
      end
      // report: max of running answers
      sac_pkg::S_RP_RD: nd_raddr = cnt_r[NW-1:0];
      sac_pkg::S_RP_CMP: begin
        if (rd_ba > best_r) best_nxt = rd_ba;
        cnt_nxt = cnt_r + CTW'(1);
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sac_pkg::S_CLEAR;
      cnt_r       <= '0;
      nc_r        <= CW'(1);
      last_r      <= '0;
      ref_len_r   <= '0;
      mnode_r     <= '0;
      mlen_r      <= '0;
      started_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      nc_r      <= nc_nxt;
      last_r    <= last_nxt;
      ref_len_r <= ref_len_nxt;
      mnode_r   <= mnode_nxt;
      mlen_r    <= mlen_nxt;
      started_r <= started_nxt;
      if (state_r == sac_pkg::S_DONE) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    sym_r    <= sym_nxt;
    status_r <= status_nxt;
    p_r      <= p_nxt;
    cur_r    <= cur_nxt;
    q_r      <= q_nxt;
    cl_r     <= cl_nxt;
    qlink_r  <= qlink_nxt;
    lenp_r   <= lenp_nxt;
    len_r    <= len_nxt;
    acc_r    <= acc_nxt;
    u_r      <= u_nxt;
    urec_r   <= urec_nxt;
    best_r   <= best_nxt;
    if (state_r == sac_pkg::S_DONE) begin
      out_status_r <= status_r;
      if (op_r == sac_pkg::OP_REPORT) begin
        out_answer_r <= (best32 > 32'(sac_pkg::ANS_MAX)) ? sac_pkg::ANS_W'(sac_pkg::ANS_MAX)
                                                          : best32[sac_pkg::ANS_W-1:0];
      end else begin
        out_answer_r <= '0;
      end
    end
  end

  // checks
  a_nc_cap: assert property (@(posedge clk) disable iff (!rst_n) nc_r <= CW'(NC))
    else $error("node count beyond capacity");
  a_done_empty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == sac_pkg::S_DONE |-> !out_valid_r)
    else $error("result written over a pending beat");
  a_started_holds: assert property (@(posedge clk) disable iff (!rst_n)
    started_r |=> started_r)
    else $error("matching flag dropped");
  a_ref_len: assert property (@(posedge clk) disable iff (!rst_n)
    ref_len_r <= LW'(MAX_REF_LEN))
    else $error("reference length beyond limit");

endmodule
`default_nettype wire
